// ----- rtl/spr_pkg.sv -----
`default_nettype none
package spr_pkg;
  localparam int MaxTrackers = 16;
  localparam int MaxPoints = 64;
  localparam int CoordWidth = 24;
  localparam int TrkW = 4;
  localparam int CntW = 7;
  localparam int DiffW = CoordWidth + 1;
  localparam int SqW = 2 * DiffW + 2;
  localparam int LenW = DiffW + 1;
  // dividend holds step * |d| <= S, so it needs the width of the squared sum
  localparam int NumW = SqW;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] CfgMinMove = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgSpacing = 1'd1;

  typedef struct packed {
    logic load;
    logic store;
    logic sq_start;
    logic sqrt_start;
    logic len_load;
    logic div_start;
    logic div_take;
    logic emit;
    logic out_valid;
  } spr_cmd_t;

  typedef struct packed {
    logic skip;
    logic unset;
    logic small_move;
    logic busy;
    logic div_busy;
    logic ax_last;
    logic pt_phase;
    logic last;
  } spr_sts_t;
endpackage
`default_nettype wire

// ----- rtl/spr_if.sv -----
`default_nettype none
interface spr_in_if;
  import spr_pkg::*;
  logic valid;
  logic ready;
  logic req_type;
  logic [TrkW-1:0] tracker_index;
  logic signed [CoordWidth-1:0] pos_x;
  logic signed [CoordWidth-1:0] pos_y;
  logic signed [CoordWidth-1:0] pos_z;
  logic [15:0] brush_radius;
  modport source (output valid, req_type, tracker_index, pos_x, pos_y, pos_z, brush_radius,
                  input ready);
  modport sink (input valid, req_type, tracker_index, pos_x, pos_y, pos_z, brush_radius,
                output ready);
endinterface

interface spr_out_if;
  import spr_pkg::*;
  logic valid;
  logic ready;
  logic [TrkW-1:0] out_tracker;
  logic signed [CoordWidth-1:0] point_x;
  logic signed [CoordWidth-1:0] point_y;
  logic signed [CoordWidth-1:0] point_z;
  logic [15:0] out_radius;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic last_point;
  logic truncated;
  modport source (output valid, out_tracker, point_x, point_y, point_z, out_radius,
                  dir_x, dir_y, dir_z, last_point, truncated, input ready);
  modport sink (input valid, out_tracker, point_x, point_y, point_z, out_radius,
                dir_x, dir_y, dir_z, last_point, truncated, output ready);
endinterface
`default_nettype wire

// ----- rtl/spr_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle, rounds half away from zero on magnitudes.
module spr_div
  import spr_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [NumW-1:0] num,
  input  wire logic [LenW-1:0] den,
  output logic                 busy,
  output logic [NumW-1:0]      quo
);
  localparam int BitW = $clog2(NumW + 1);
  logic [NumW-1:0] n_r, q_r;
  logic [LenW:0]   rem_r;
  logic [LenW-1:0] d_r;
  logic [BitW-1:0] cnt_r;
  logic            busy_r;
  logic [LenW:0]   sh;

  assign sh = {rem_r[LenW-1:0], n_r[NumW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= BitW'(NumW);
      // pre-add den/2 for rounding
      n_r <= num + NumW'(den >> 1);
      d_r <= den;
      rem_r <= '0;
      q_r <= '0;
    end else if (busy_r) begin
      n_r <= n_r << 1;
      if (sh >= {1'b0, d_r}) begin
        rem_r <= sh - {1'b0, d_r};
        q_r <= {q_r[NumW-2:0], 1'b1};
      end else begin
        rem_r <= sh;
        q_r <= {q_r[NumW-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == BitW'(1)) busy_r <= 1'b0;
    end
  end
  assign busy = busy_r;
  assign quo = q_r;
endmodule
`default_nettype wire

// ----- rtl/spr_datapath.sv -----
`default_nettype none
module spr_datapath
  import spr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire spr_cmd_t             cmd,
  output spr_sts_t                  sts,
  input  wire logic                 cfg_we,
  input  wire logic [CfgIdxW-1:0]   cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data,
  spr_in_if.sink                    in_ch,
  spr_out_if.source                 out_ch
);
  localparam int SqrtItW = $clog2(SqW / 2 + 1);

  logic [CoordWidth-1:0] mem_x [MaxTrackers];
  logic [CoordWidth-1:0] mem_y [MaxTrackers];
  logic [CoordWidth-1:0] mem_z [MaxTrackers];
  logic [MaxTrackers-1:0] set_r;
  logic [47:0] min_r;
  logic [15:0] sp_cfg_r;

  logic [TrkW-1:0] trk_r;
  logic [15:0] rad_r;
  logic seed_r;
  logic signed [CoordWidth-1:0] nx_r, ny_r, nz_r, px_r, py_r, pz_r;
  logic signed [DiffW-1:0] d_r [3];
  logic [SqW-1:0] s_r;
  logic sq_busy_r;
  logic [SqW-1:0] rem_r, root_r;
  logic [SqrtItW-1:0] sq_it_r;
  logic sqrt_busy_r;
  logic [LenW-1:0] len_r, step_r;
  logic [15:0] sp_r;
  logic [CntW-1:0] i_r;
  logic [1:0] ax_r;
  logic pt_phase_r;
  logic signed [15:0] dir_r [3];
  logic signed [CoordWidth-1:0] pt_r [3];

  logic signed [DiffW-1:0] d_sel;
  logic [DiffW-1:0] mag_sel;
  logic [2*DiffW-1:0] sq_w;
  logic [SqW-1:0] bit_w, trial;
  logic [LenW+DiffW-1:0] pmul;
  logic [NumW-1:0] div_num, quo, q_sgn;
  logic div_busy;
  logic signed [CoordWidth-1:0] base_sel;
  logic [LenW:0] nstep;
  logic [15+CntW:0] cap_span;
  logic trunc_w;
  logic last_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '0;
      sp_cfg_r <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgMinMove: min_r <= cfg_data;
        CfgSpacing: sp_cfg_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign d_sel = d_r[ax_r];
  assign mag_sel = d_sel[DiffW-1] ? DiffW'(-d_sel) : DiffW'(d_sel);
  assign sq_w = mag_sel * mag_sel;
  assign bit_w = SqW'(1) << (2 * sq_it_r);
  assign trial = root_r + bit_w;
  // dir phase: |d| * 16384; point phase: |d| * i * spacing
  assign pmul = step_r * mag_sel;
  assign div_num = pt_phase_r ? NumW'(pmul) : NumW'({mag_sel, 14'd0});
  assign q_sgn = d_sel[DiffW-1] ? -quo : quo;
  assign base_sel = (ax_r == 2'd0) ? px_r : (ax_r == 2'd1) ? py_r : pz_r;
  assign nstep = {1'b0, step_r} + (LenW+1)'(sp_r);
  assign cap_span = sp_r * CntW'(MaxPoints);
  // count capped when len / sp + 1 > MaxPoints, i.e. len >= MaxPoints * sp
  assign trunc_w = LenW'(cap_span) <= len_r;
  assign last_w = trunc_w ? (i_r == CntW'(MaxPoints - 1)) : (nstep > {1'b0, len_r});

  spr_div u_div (.clk, .rst_n, .start(cmd.div_start), .num(div_num), .den(len_r),
                 .busy(div_busy), .quo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_r <= '0;
      sq_busy_r <= 1'b0;
      sqrt_busy_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        trk_r <= in_ch.tracker_index;
        rad_r <= in_ch.brush_radius;
        nx_r <= in_ch.pos_x;
        ny_r <= in_ch.pos_y;
        nz_r <= in_ch.pos_z;
        px_r <= set_r[in_ch.tracker_index] ? mem_x[in_ch.tracker_index] : '0;
        py_r <= set_r[in_ch.tracker_index] ? mem_y[in_ch.tracker_index] : '0;
        pz_r <= set_r[in_ch.tracker_index] ? mem_z[in_ch.tracker_index] : '0;
        seed_r <= in_ch.req_type;
      end
      if (cmd.store) begin
        mem_x[trk_r] <= nx_r;
        mem_y[trk_r] <= ny_r;
        mem_z[trk_r] <= nz_r;
        set_r[trk_r] <= 1'b1;
      end
      if (cmd.sq_start) begin
        d_r[0] <= DiffW'(nx_r) - DiffW'(px_r);
        d_r[1] <= DiffW'(ny_r) - DiffW'(py_r);
        d_r[2] <= DiffW'(nz_r) - DiffW'(pz_r);
        s_r <= '0;
        ax_r <= 2'd0;
        sq_busy_r <= 1'b1;
      end else if (sq_busy_r) begin
        // one axis square a cycle
        s_r <= s_r + SqW'(sq_w);
        if (ax_r == 2'd2) begin
          ax_r <= 2'd0;
          sq_busy_r <= 1'b0;
        end else begin
          ax_r <= ax_r + 2'd1;
        end
      end
      if (cmd.sqrt_start) begin
        rem_r <= s_r;
        root_r <= '0;
        sq_it_r <= SqrtItW'(SqW / 2 - 1);
        sqrt_busy_r <= 1'b1;
        sp_r <= (sp_cfg_r == 16'd0) ? 16'd1 : sp_cfg_r;
      end else if (sqrt_busy_r) begin
        if (rem_r >= trial) begin
          rem_r <= rem_r - trial;
          root_r <= (root_r >> 1) + bit_w;
        end else begin
          root_r <= root_r >> 1;
        end
        if (sq_it_r == '0) begin
          sqrt_busy_r <= 1'b0;
        end
        sq_it_r <= sq_it_r - 1'b1;
      end
      if (cmd.len_load) begin
        len_r <= (root_r == '0) ? LenW'(1) : LenW'(root_r);
        step_r <= '0;
        i_r <= '0;
        ax_r <= 2'd0;
        pt_phase_r <= 1'b0;
      end
      if (cmd.div_take) begin
        if (pt_phase_r) begin
          pt_r[ax_r] <= base_sel + q_sgn[CoordWidth-1:0];
        end else begin
          dir_r[ax_r] <= q_sgn[15:0];
        end
        if (ax_r == 2'd2) begin
          ax_r <= 2'd0;
          pt_phase_r <= 1'b1;
        end else begin
          ax_r <= ax_r + 2'd1;
        end
      end
      if (cmd.emit) begin
        i_r <= i_r + 1'b1;
        step_r <= step_r + LenW'(sp_r);
      end
    end
  end

  assign sts.skip = {1'b0, in_ch.tracker_index} >= (TrkW+1)'(MaxTrackers);
  assign sts.unset = seed_r || (px_r == '0 && py_r == '0 && pz_r == '0);
  assign sts.small_move = (SqW'(min_r) >= s_r);
  assign sts.busy = sq_busy_r | sqrt_busy_r;
  assign sts.div_busy = div_busy;
  assign sts.ax_last = (ax_r == 2'd2);
  assign sts.pt_phase = pt_phase_r;
  assign sts.last = last_w;

  assign in_ch.ready = cmd.load;
  assign out_ch.valid = cmd.out_valid;
  assign out_ch.out_tracker = trk_r;
  assign out_ch.point_x = pt_r[0];
  assign out_ch.point_y = pt_r[1];
  assign out_ch.point_z = pt_r[2];
  assign out_ch.out_radius = rad_r;
  assign out_ch.dir_x = dir_r[0];
  assign out_ch.dir_y = dir_r[1];
  assign out_ch.dir_z = dir_r[2];
  assign out_ch.last_point = last_w;
  assign out_ch.truncated = trunc_w;
endmodule
`default_nettype wire

// ----- rtl/spr_ctrl.sv -----
`default_nettype none
module spr_ctrl
  import spr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     out_ready,
  input  wire spr_sts_t sts,
  output spr_cmd_t      cmd
);
  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SQ, S_ROOT, S_DIV, S_WAIT, S_OUT
  } state_t;
  state_t state_r, state_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) begin
        // out-of-range trackers are taken and dropped
        cmd.load = 1'b1;
        if (!sts.skip) state_nxt = S_CHECK;
      end
      S_CHECK: if (sts.unset) begin
        cmd.store = 1'b1;
        state_nxt = S_IDLE;
      end else begin
        cmd.sq_start = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: if (!sts.busy) begin
        if (sts.small_move) state_nxt = S_IDLE;
        else begin
          cmd.sqrt_start = 1'b1;
          cmd.store = 1'b1;
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: if (!sts.busy) begin
        cmd.len_load = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: if (!sts.div_busy) begin
        cmd.div_take = 1'b1;
        state_nxt = (sts.ax_last && sts.pt_phase) ? S_OUT : S_DIV;
      end
      S_OUT: begin
        cmd.out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit = 1'b1;
          state_nxt = sts.last ? S_IDLE : S_DIV;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

// ----- rtl/stroke_point_resampler_core.sv -----
`default_nettype none
// channel | dir | fields
// in_     | in  | req_type, tracker_index, pos_x/y/z, brush_radius
// out_    | out | out_tracker, point_x/y/z, out_radius, dir_x/y/z, last_point, truncated
// cfg_    | in  | cfg_we, cfg_index, cfg_data (no read-back)
// One word at a time. A seed or unset tracker is only stored; a small move ends after the squares.
// A move of n points runs the squares and root, then the three direction divisions,
// then for each point three divisions plus one output handshake.
// Reset is synchronous, clears all trackers to unset and the config to defaults.
// A stalled output holds the controller; no new word is taken until the move is done.
module stroke_point_resampler_core
  import spr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  spr_in_if.sink                   in_ch,
  spr_out_if.source                out_ch
);
  spr_cmd_t cmd;
  spr_sts_t sts;

  spr_ctrl u_ctrl (.clk, .rst_n, .in_valid(in_ch.valid), .out_ready(out_ch.ready),
                   .sts, .cmd);
  spr_datapath u_dp (.clk, .rst_n, .cmd, .sts, .cfg_we, .cfg_index, .cfg_data,
                     .in_ch, .out_ch);
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none
module tb_top;
  import spr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // longest legal gap between accepted words: a 64 point move with stalls,
  // or the deliberate output hold-off, several times over
  localparam int StallLimit = 40000;
  localparam int HoldCycles = 3000;
  localparam int DrainCycles = 600;

  typedef struct packed {
    logic                         req_type;
    logic [TrkW-1:0]              tracker;
    logic signed [CoordWidth-1:0] x;
    logic signed [CoordWidth-1:0] y;
    logic signed [CoordWidth-1:0] z;
    logic [15:0]                  radius;
  } pos_word_t;

  typedef struct packed {
    logic [TrkW-1:0]              tracker;
    logic signed [CoordWidth-1:0] x;
    logic signed [CoordWidth-1:0] y;
    logic signed [CoordWidth-1:0] z;
    logic [15:0]                  radius;
    logic signed [15:0]           dx;
    logic signed [15:0]           dy;
    logic signed [15:0]           dz;
    logic                         last;
    logic                         trunc;
  } point_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  spr_in_if  in_ch ();
  spr_out_if out_ch ();

  stroke_point_resampler_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stimulus and expected points
  pos_word_t   pos_queue[$];
  point_word_t point_queue[$];
  pos_word_t   cur_word;
  int          fails = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_token = 0;
  int          hold_seen = 0;
  int          hold_cnt = 0;
  int          quiet_cycles = 0;

  // shadow of the block: stored position per tracker and the two registers
  longint      trk_x[MaxTrackers];
  longint      trk_y[MaxTrackers];
  longint      trk_z[MaxTrackers];
  longint unsigned move_thresh;
  longint unsigned spacing_q8;

  // positions used by the generator to build coherent strokes
  longint      gen_x[MaxTrackers];
  longint      gen_y[MaxTrackers];
  longint      gen_z[MaxTrackers];

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // round(d * k / den), ties away from zero
  function automatic longint round_scale(longint d, longint unsigned k, longint unsigned den);
    longint unsigned m;
    longint unsigned q;
    m = (d < 0) ? longint'(-d) : longint'(d);
    q = (m * k + den / 2) / den;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  // work out the points one accepted word causes and update the stored position
  task automatic resample_move(input pos_word_t w);
    longint nx, ny, nz, px, py, pz, ddx, ddy, ddz;
    longint unsigned s, len, sp, cnt;
    int n;
    logic trunc;
    point_word_t p;
    nx = w.x; ny = w.y; nz = w.z;
    px = trk_x[w.tracker]; py = trk_y[w.tracker]; pz = trk_z[w.tracker];
    if (w.req_type || (px == 0 && py == 0 && pz == 0)) begin
      trk_x[w.tracker] = nx; trk_y[w.tracker] = ny; trk_z[w.tracker] = nz;
      return;
    end
    ddx = nx - px; ddy = ny - py; ddz = nz - pz;
    s = ddx * ddx + ddy * ddy + ddz * ddz;
    if (s <= move_thresh) return;   // small move: nothing stored either
    len = int_sqrt(s);
    if (len == 0) len = 1;
    sp = (spacing_q8 == 0) ? 1 : spacing_q8;
    cnt = len / sp + 1;
    trunc = cnt > MaxPoints;
    n = trunc ? MaxPoints : int'(cnt);
    for (int i = 0; i < n; i++) begin
      p.tracker = w.tracker;
      p.x = CoordWidth'(px + round_scale(ddx, i * sp, len));
      p.y = CoordWidth'(py + round_scale(ddy, i * sp, len));
      p.z = CoordWidth'(pz + round_scale(ddz, i * sp, len));
      p.radius = w.radius;
      p.dx = 16'(round_scale(ddx, 16384, len));
      p.dy = 16'(round_scale(ddy, 16384, len));
      p.dz = 16'(round_scale(ddz, 16384, len));
      p.last = (i == n - 1);
      p.trunc = trunc;
      point_queue.push_back(p);
    end
    trk_x[w.tracker] = nx; trk_y[w.tracker] = ny; trk_z[w.tracker] = nz;
  endtask

  // driver: a word stays on the bus until taken, then the next one (or a gap)
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) resample_move(cur_word);
      if (!in_ch.valid || in_ch.ready) begin
        if (pos_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_word = pos_queue.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.req_type      <= cur_word.req_type;
          in_ch.tracker_index <= cur_word.tracker;
          in_ch.pos_x         <= cur_word.x;
          in_ch.pos_y         <= cur_word.y;
          in_ch.pos_z         <= cur_word.z;
          in_ch.brush_radius  <= cur_word.radius;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // output ready: random stalls, plus a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      hold_cnt = HoldCycles;
    end else if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
    end
    out_ch.ready <= rst_n && (hold_cnt == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: every accepted point against the oldest expected one
  always @(posedge clk) begin
    point_word_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_tracker, out_ch.point_x, out_ch.point_y, out_ch.point_z,
              out_ch.out_radius, out_ch.dir_x, out_ch.dir_y, out_ch.dir_z,
              out_ch.last_point, out_ch.truncated};
      if (point_queue.size() == 0) begin
        $display("%0t: unexpected point %h", $time, got);
        fails++;
      end else begin
        want = point_queue.pop_front();
        if (got !== want) begin
          $display("%0t: point mismatch expected %h actual %h", $time, want, got);
          fails++;
        end
      end
    end
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic busy();
    return pos_queue.size() > 0 || in_ch.valid || point_queue.size() > 0;
  endfunction

  task automatic wait_idle();
    while (busy()) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);   // seeds and small moves leave nothing to wait on
  endtask

  task automatic set_cfg(input longint unsigned thresh, input longint unsigned sp);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CfgMinMove; cfg_data <= thresh[47:0];
    @(posedge clk);
    cfg_index <= CfgSpacing; cfg_data <= CfgDataW'(sp[15:0]);
    @(posedge clk);
    cfg_we <= 1'b0;
    move_thresh = thresh[47:0];
    spacing_q8 = sp[15:0];
  endtask

  function automatic longint clip(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  task automatic add_word(input logic rt, input int trk, input longint x, input longint y,
                          input longint z, input int rad);
    pos_word_t w;
    w.req_type = rt; w.tracker = trk[TrkW-1:0];
    w.x = x[CoordWidth-1:0]; w.y = y[CoordWidth-1:0]; w.z = z[CoordWidth-1:0];
    w.radius = rad[15:0];
    pos_queue.push_back(w);
    gen_x[trk] = x; gen_y[trk] = y; gen_z[trk] = z;
  endtask

  // mostly strokes: a seed then draw steps of a few spacings; some noise
  task automatic add_strokes(input int n, input int reach);
    int trk, pick;
    longint r;
    for (int k = 0; k < n; k++) begin
      trk = $urandom_range(MaxTrackers - 1);
      pick = $urandom_range(99);
      if (pick < 8) begin
        add_word(1'b1, trk, clip($signed($urandom_range(2000, 0)) - 1000),
                 $signed($urandom_range(2000, 0)) - 1000, 1 + $urandom_range(500),
                 $urandom_range(65535));
      end else if (pick < 12) begin
        // full-range noise, often a long capped move
        add_word($urandom_range(1), trk, $signed(24'($urandom)), $signed(24'($urandom)),
                 $signed(24'($urandom)), $urandom_range(65535));
      end else begin
        r = (pick < 20) ? 3 : reach;
        add_word(1'b0, trk, clip(gen_x[trk] + $signed($urandom_range(2 * r, 0)) - r),
                 clip(gen_y[trk] + $signed($urandom_range(2 * r, 0)) - r),
                 clip(gen_z[trk] + $signed($urandom_range(2 * r, 0)) - r),
                 $urandom_range(65535));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_ch.valid = 1'b0; in_ch.req_type = 1'b0; in_ch.tracker_index = '0;
    in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0; in_ch.brush_radius = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < MaxTrackers; i++) begin
      trk_x[i] = 0; trk_y[i] = 0; trk_z[i] = 0;
      gen_x[i] = 0; gen_y[i] = 0; gen_z[i] = 0;
    end
    move_thresh = 0;
    spacing_q8 = 256;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset config
    add_word(1'b0, 0, 100, 200, 300, 0);              // draw on unset tracker seeds it
    add_word(1'b0, 0, 612, 200, 300, 65535);          // two spacings along x
    add_word(1'b0, 0, 612, 200, 300, 1234);           // zero move, below threshold
    add_word(1'b1, 1, 0, 0, 0, 7);                    // zero seed leaves it unset
    add_word(1'b0, 1, -300, 50, -20, 9);              // still unset: seeds
    add_word(1'b0, 1, -300, -700, 400, 11);
    add_word(1'b1, 15, 8388607, 8388607, 8388607, 0);
    add_word(1'b0, 15, -8388608, -8388608, -8388608, 65535); // longest move, capped
    add_word(1'b1, 2, -8388608, 8388607, 1, 5);
    add_word(1'b0, 2, -8388608, 8388607, -255, 5);    // negative z only
    add_word(1'b0, 2, -8388608, 8388351, -255, 6);    // negative y only
    add_word(1'b1, 3, 1, 0, 0, 1);
    add_word(1'b0, 3, 2, 0, 0, 2);                    // length one, single point
    add_word(1'b0, 3, 2, 1, 1, 3);
    wait_idle();

    // top thresholds, widest spacing
    set_cfg(64'hFFFF_FFFF_FFFF, 65535);
    add_word(1'b0, 4, 1000, 1000, 1000, 1);
    add_word(1'b0, 4, 9000, 9000, 9000, 2);           // small move under huge threshold
    add_word(1'b0, 4, -8388608, -8388608, -8388608, 3);
    add_word(1'b0, 4, 8388607, 8388607, 8388607, 4);
    wait_idle();

    // zero spacing acts as one: every move capped
    set_cfg(0, 0);
    add_word(1'b0, 5, 10, 10, 10, 100);
    add_word(1'b0, 5, 500, -40, 90, 200);
    wait_idle();

    set_cfg(1000, 256);
    add_strokes(80, 1024);
    wait_idle();

    set_cfg(0, 128);
    send_idle_pct = 77;
    add_strokes(75, 512);
    wait_idle();

    // receiver stalls, with one long hold-off so the input backs up
    set_cfg(50000, 300);
    send_idle_pct = 0;
    recv_idle_pct = 77;
    hold_token++;
    add_strokes(75, 1200);
    wait_idle();

    set_cfg($urandom_range(20000), $urandom_range(1024, 64));
    send_idle_pct = 28;
    recv_idle_pct = 28;
    add_strokes(75, 2048);
    wait_idle();

    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
